FILE: src/rbc_pkg.sv
// package for the reconnect backoff controller
// holds event, outcome, phase and register codes plus shared structs
// no dependencies
package rbc_pkg;

    localparam int unsigned DELAY_W    = 26;
    localparam int unsigned WAITED_W   = 27;
    localparam int unsigned BASE_W     = 16;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned OP_W       = 3;
    localparam int unsigned OUTCOME_W  = 2;
    localparam int unsigned PHASE_W    = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned SHIFT_W    = 4;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 40;

    localparam logic [OP_W-1:0] OP_START   = 3'd0;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd1;
    localparam logic [OP_W-1:0] OP_OUTCOME = 3'd2;
    localparam logic [OP_W-1:0] OP_LIVE    = 3'd3;
    localparam logic [OP_W-1:0] OP_DROP    = 3'd4;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd5;

    localparam logic [OUTCOME_W-1:0] OC_OK           = 2'd0;
    localparam logic [OUTCOME_W-1:0] OC_BUILD_FAILED = 2'd1;
    localparam logic [OUTCOME_W-1:0] OC_START_FAILED = 2'd2;

    localparam logic [PHASE_W-1:0] PH_IDLE         = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CONNECTING   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LIVE         = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RECONNECTING = 3'd3;
    localparam logic [PHASE_W-1:0] PH_ERROR        = 3'd4;
    localparam logic [PHASE_W-1:0] PH_STOPPED      = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CREDENTIALS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY   = 3'd5;

    localparam logic [SHIFT_W-1:0]  SHIFT_CAP = 4'd10;
    localparam logic [WAITED_W-1:0] TICK_MS   = 27'd100;

    localparam logic [COUNT_W-1:0] RST_MAX_RETRIES = 8'd5;
    localparam logic [BASE_W-1:0]  RST_BASE_DELAY  = 16'd2000;
    localparam logic [DELAY_W-1:0] RST_MAX_DELAY   = 26'd60000;

    typedef struct packed {
        logic               enabled;
        logic               credentials_present;
        logic               auto_reconnect;
        logic [COUNT_W-1:0] max_retries;
        logic [BASE_W-1:0]  base_delay_ms;
        logic [DELAY_W-1:0] max_delay_ms;
    } rbc_cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [OUTCOME_W-1:0] launch_outcome;
    } rbc_event_t;

    typedef struct packed {
        logic               retries_exhausted;
        logic [COUNT_W-1:0] attempt_number;
        logic [DELAY_W-1:0] retry_delay_ms;
        logic               start_taken;
        logic               launch_request;
        logic [PHASE_W-1:0] link_state;
    } rbc_result_t;

endpackage

FILE: src/rbc_cfg_regs.sv
// configuration registers of the reconnect backoff controller
// depends on rbc_pkg
module rbc_cfg_regs
    import rbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DELAY_W-1:0]   cfg_wdata,
    output rbc_cfg_t             cfg
);

    rbc_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled             <= 1'b0;
            cfg_reg.credentials_present <= 1'b0;
            cfg_reg.auto_reconnect      <= 1'b1;
            cfg_reg.max_retries         <= RST_MAX_RETRIES;
            cfg_reg.base_delay_ms       <= RST_BASE_DELAY;
            cfg_reg.max_delay_ms        <= RST_MAX_DELAY;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_ENABLED:     cfg_reg.enabled             <= cfg_wdata[0];
                REG_CREDENTIALS: cfg_reg.credentials_present <= cfg_wdata[0];
                REG_AUTO:        cfg_reg.auto_reconnect      <= cfg_wdata[0];
                REG_MAX_RETRIES: cfg_reg.max_retries         <= cfg_wdata[COUNT_W-1:0];
                REG_BASE_DELAY:  cfg_reg.base_delay_ms       <= cfg_wdata[BASE_W-1:0];
                REG_MAX_DELAY:   cfg_reg.max_delay_ms        <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/rbc_in_stage.sv
// input register stage: holds one accepted event request
// depends on rbc_pkg
module rbc_in_stage
    import rbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  rbc_event_t in_event,
    output logic       ev_valid,
    input  logic       ev_take,
    output rbc_event_t ev
);

    logic       valid_reg;
    rbc_event_t ev_reg;

    assign in_ready = !valid_reg || ev_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ev_reg <= in_event;
        end
    end

    assign ev_valid = valid_reg;
    assign ev       = ev_reg;

endmodule

FILE: src/rbc_core.sv
// supervisor state and single-pass next-state logic with backoff delay
// depends on rbc_pkg
module rbc_core
    import rbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        ev_fire,
    input  rbc_event_t  ev,
    input  rbc_cfg_t    cfg,
    output rbc_result_t res
);

    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [COUNT_W-1:0]  attempt_reg, attempt_next;
    logic                stopping_reg, stopping_next;
    logic                wait_reg, wait_next;
    logic [WAITED_W-1:0] waited_reg, waited_next;
    logic [DELAY_W-1:0]  pending_reg, pending_next;
    logic                retry_launch_reg, retry_launch_next;

    logic                allow_retry;
    logic                exhausted;
    logic [SHIFT_W-1:0]  shift_amt;
    logic [DELAY_W-1:0]  shifted;
    logic [DELAY_W-1:0]  delay;
    logic [WAITED_W-1:0] waited_sum;
    logic                do_retry;

    // backoff delay from the attempt count before the event
    assign allow_retry = !stopping_reg && cfg.auto_reconnect;
    assign exhausted   = attempt_reg >= cfg.max_retries;
    assign shift_amt   = (attempt_reg < {4'd0, SHIFT_CAP}) ? attempt_reg[SHIFT_W-1:0]
                                                            : SHIFT_CAP;
    assign shifted     = {{(DELAY_W-BASE_W){1'b0}}, cfg.base_delay_ms} << shift_amt;
    assign delay       = (shifted > cfg.max_delay_ms) ? cfg.max_delay_ms : shifted;
    assign waited_sum  = waited_reg + TICK_MS;

    always_comb
    begin
        phase_next        = phase_reg;
        attempt_next      = attempt_reg;
        stopping_next     = stopping_reg;
        wait_next         = wait_reg;
        waited_next       = waited_reg;
        pending_next      = pending_reg;
        retry_launch_next = retry_launch_reg;
        do_retry          = 1'b0;
        res               = '0;

        case (ev.operation)
            OP_START:
            begin
                if (cfg.enabled)
                begin
                    if (!cfg.credentials_present)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        res.start_taken    = 1'b1;
                        res.launch_request = 1'b1;
                        stopping_next      = 1'b0;
                        attempt_next       = '0;
                        phase_next         = PH_CONNECTING;
                        wait_next          = 1'b0;
                        waited_next        = '0;
                        pending_next       = '0;
                        retry_launch_next  = 1'b0;
                    end
                end
            end
            OP_STOP:
            begin
                stopping_next     = 1'b1;
                wait_next         = 1'b0;
                waited_next       = '0;
                pending_next      = '0;
                retry_launch_next = 1'b0;
                phase_next        = PH_STOPPED;
            end
            OP_OUTCOME:
            begin
                if (!stopping_reg)
                begin
                    if (retry_launch_reg)
                    begin
                        if (ev.launch_outcome == OC_OK)
                        begin
                            retry_launch_next = 1'b0;
                            phase_next        = PH_CONNECTING;
                        end
                        else if (ev.launch_outcome == OC_BUILD_FAILED ||
                                 ev.launch_outcome == OC_START_FAILED)
                        begin
                            retry_launch_next = 1'b0;
                            phase_next        = PH_ERROR;
                            do_retry          = 1'b1;
                        end
                    end
                    else if (ev.launch_outcome == OC_BUILD_FAILED)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else if (ev.launch_outcome == OC_START_FAILED)
                    begin
                        phase_next = PH_ERROR;
                        do_retry   = 1'b1;
                    end
                end
            end
            OP_LIVE:
            begin
                if (!stopping_reg)
                begin
                    attempt_next = '0;
                    phase_next   = PH_LIVE;
                end
            end
            OP_DROP:
            begin
                if (stopping_reg)
                begin
                    phase_next = PH_STOPPED;
                end
                else
                begin
                    phase_next = PH_RECONNECTING;
                    do_retry   = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (wait_reg && !stopping_reg)
                begin
                    waited_next = waited_sum;
                    if (waited_sum >= {1'b0, pending_reg})
                    begin
                        wait_next          = 1'b0;
                        waited_next        = '0;
                        retry_launch_next  = 1'b1;
                        res.launch_request = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (do_retry && allow_retry)
        begin
            if (exhausted)
            begin
                phase_next            = PH_ERROR;
                res.retries_exhausted = 1'b1;
            end
            else
            begin
                attempt_next       = attempt_reg + 8'd1;
                phase_next         = PH_RECONNECTING;
                wait_next          = 1'b1;
                waited_next        = '0;
                pending_next       = delay;
                res.retry_delay_ms = delay;
                res.attempt_number = attempt_reg + 8'd1;
                // zero delay launches at once
                if (delay == '0)
                begin
                    wait_next          = 1'b0;
                    retry_launch_next  = 1'b1;
                    res.launch_request = 1'b1;
                end
            end
        end

        res.link_state = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            attempt_reg      <= '0;
            stopping_reg     <= 1'b0;
            wait_reg         <= 1'b0;
            waited_reg       <= '0;
            pending_reg      <= '0;
            retry_launch_reg <= 1'b0;
        end
        else if (ev_fire)
        begin
            phase_reg        <= phase_next;
            attempt_reg      <= attempt_next;
            stopping_reg     <= stopping_next;
            wait_reg         <= wait_next;
            waited_reg       <= waited_next;
            pending_reg      <= pending_next;
            retry_launch_reg <= retry_launch_next;
        end
    end

endmodule

FILE: src/rbc_out_stage.sv
// result register stage toward the output stream
// depends on rbc_pkg
module rbc_out_stage
    import rbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    output logic        res_ready,
    input  rbc_result_t res,
    output logic        out_valid,
    input  logic        out_ready,
    output rbc_result_t out_res
);

    logic        valid_reg;
    rbc_result_t res_reg;

    assign res_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

FILE: src/reconnect_backoff_controller_top.sv
// Reconnect backoff controller: one event request enters per clock when the
// output side keeps up; an accepted request passes the input register, and
// its result is written to the result register by the same state update that
// changes the link state, attempt count and retry wait. The backoff delay is
// min(base << min(attempt, 10), max) and is waited out in 100 ms ticks.
// depends on rbc_pkg, rbc_cfg_regs, rbc_in_stage, rbc_core, rbc_out_stage
module reconnect_backoff_controller_top
    import rbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DELAY_W-1:0]    cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // launch_outcome[1:0], zero pad
    input  logic [OP_W-1:0]       s_tuser,   // operation[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // link_state[2:0], launch_request[3], start_taken[4],
    // retry_delay_ms[30:5], attempt_number[38:31], retries_exhausted[39]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    rbc_cfg_t    cfg;
    rbc_event_t  in_event;
    rbc_event_t  ev;
    rbc_result_t res;
    rbc_result_t out_res;
    logic        ev_valid;
    logic        res_ready;
    logic        ev_fire;

    assign in_event.operation      = s_tuser;
    assign in_event.launch_outcome = s_tdata[OUTCOME_W-1:0];
    assign ev_fire                 = ev_valid && res_ready;

    rbc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rbc_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_event (in_event),
        .ev_valid (ev_valid),
        .ev_take  (res_ready),
        .ev       (ev)
    );

    rbc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .ev_fire (ev_fire),
        .ev      (ev),
        .cfg     (cfg),
        .res     (res)
    );

    rbc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (ev_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res;

endmodule

FILE: src/rbc_checker.sv
// port-level checks for the reconnect backoff controller
// depends on rbc_pkg; bound to reconnect_backoff_controller_top
module rbc_checker
    import rbc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // held result while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // accepted start always moves to connecting with a launch
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[2:0] == PH_CONNECTING && m_tdata[3])
        else $error("start taken without connecting launch");

    // retry refused at the retry limit lands in error and schedules nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[39] |->
            m_tdata[2:0] == PH_ERROR && m_tdata[38:5] == '0 && !m_tdata[3])
        else $error("exhausted result inconsistent");

    // a scheduled retry reports reconnecting
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[38:31] != '0 |-> m_tdata[2:0] == PH_RECONNECTING)
        else $error("retry scheduled outside reconnecting");

endmodule

bind reconnect_backoff_controller_top rbc_checker u_rbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: test/tb.sv
// testbench for reconnect_backoff_controller_top: random event requests with idle and stall bursts
// a behavioral backoff predictor fills a queue of expected results that the monitor checks
// depends on rbc_pkg and the rtl of the controller
`timescale 1ns / 100ps

module tb;
    import rbc_pkg::*;

    localparam int unsigned OP_SPARE_A   = 6;
    localparam int unsigned OP_SPARE_B   = 7;
    localparam int unsigned OC_UNDEFINED = 3;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SETTLE_CYCLES = 4;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DELAY_W-1:0]    cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // launch_outcome[1:0], zero pad
    logic [OP_W-1:0]       s_tuser = '0;   // operation[2:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // link_state[2:0], launch_request[3], start_taken[4],
    // retry_delay_ms[30:5], attempt_number[38:31], retries_exhausted[39]
    logic [OUT_DATA_W-1:0] m_tdata;

    reconnect_backoff_controller_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    rbc_event_t  event_queue[$];
    rbc_result_t pending_reports[$];
    int unsigned reqs_queued = 0;
    int unsigned reqs_accepted = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    logic        bursts_on = 1'b1;
    logic        req_fire = 1'b0;

    rbc_cfg_t            cfg_q;
    logic [PHASE_W-1:0]  phase_q = PH_IDLE;
    logic [COUNT_W-1:0]  attempts_q = '0;
    logic                stopping_q = 1'b0;
    logic                wait_q = 1'b0;
    logic [WAITED_W-1:0] waited_q = '0;
    logic [DELAY_W-1:0]  delay_q = '0;
    logic                retry_launch_q = 1'b0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic issue_launch(inout rbc_result_t res);
        wait_q = 1'b0;
        waited_q = '0;
        retry_launch_q = 1'b1;
        res.launch_request = 1'b1;
    endtask

    task automatic arm_retry(inout rbc_result_t res);
        logic [31:0]        span;
        logic [SHIFT_W-1:0] sh;
        if (stopping_q || !cfg_q.auto_reconnect)
            return;
        if (attempts_q >= cfg_q.max_retries)
        begin
            phase_q = PH_ERROR;
            res.retries_exhausted = 1'b1;
            return;
        end
        sh = (attempts_q < COUNT_W'(SHIFT_CAP)) ? attempts_q[SHIFT_W-1:0] : SHIFT_CAP;
        span = {16'd0, cfg_q.base_delay_ms} << sh;
        if (span > {6'd0, cfg_q.max_delay_ms})
            span = {6'd0, cfg_q.max_delay_ms};
        attempts_q = attempts_q + 1'b1;
        phase_q = PH_RECONNECTING;
        wait_q = 1'b1;
        waited_q = '0;
        delay_q = span[DELAY_W-1:0];
        res.retry_delay_ms = delay_q;
        res.attempt_number = attempts_q;
        if (delay_q == '0)
            issue_launch(res);
    endtask

    task automatic advance_link(input logic [OP_W-1:0] op, input logic [OUTCOME_W-1:0] oc,
                                output rbc_result_t res);
        res = '0;
        case (op)
            OP_START:
                if (cfg_q.enabled)
                begin
                    if (!cfg_q.credentials_present)
                        phase_q = PH_ERROR;
                    else
                    begin
                        res.start_taken = 1'b1;
                        stopping_q = 1'b0;
                        attempts_q = '0;
                        phase_q = PH_CONNECTING;
                        wait_q = 1'b0;
                        waited_q = '0;
                        delay_q = '0;
                        retry_launch_q = 1'b0;
                        res.launch_request = 1'b1;
                    end
                end
            OP_STOP:
            begin
                stopping_q = 1'b1;
                wait_q = 1'b0;
                waited_q = '0;
                delay_q = '0;
                retry_launch_q = 1'b0;
                phase_q = PH_STOPPED;
            end
            OP_OUTCOME:
                if (!stopping_q && oc <= OC_START_FAILED)
                begin
                    if (retry_launch_q)
                    begin
                        retry_launch_q = 1'b0;
                        if (oc == OC_OK)
                            phase_q = PH_CONNECTING;
                        else
                        begin
                            phase_q = PH_ERROR;
                            arm_retry(res);
                        end
                    end
                    else if (oc == OC_BUILD_FAILED)
                        phase_q = PH_ERROR;
                    else if (oc == OC_START_FAILED)
                    begin
                        phase_q = PH_ERROR;
                        arm_retry(res);
                    end
                end
            OP_LIVE:
                if (!stopping_q)
                begin
                    attempts_q = '0;
                    phase_q = PH_LIVE;
                end
            OP_DROP:
                if (stopping_q)
                    phase_q = PH_STOPPED;
                else
                begin
                    phase_q = PH_RECONNECTING;
                    arm_retry(res);
                end
            OP_TICK:
                if (wait_q && !stopping_q)
                begin
                    waited_q = waited_q + TICK_MS;
                    if (waited_q >= {1'b0, delay_q})
                        issue_launch(res);
                end
            default:
            begin
            end
        endcase
        res.link_state = phase_q;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // request side
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || req_fire)
        begin
            if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                send_gap <= $urandom_range(0, 2);
                s_tvalid <= 1'b0;
            end
            else if (event_queue.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tuser <= event_queue[0].operation;
                s_tdata <= {6'd0, event_queue[0].launch_outcome};
                void'(event_queue.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result side
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (bursts_on && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : monitor_blk
        rbc_result_t want;
        rbc_result_t got;
        if (rst_n)
        begin
            req_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                advance_link(s_tuser, s_tdata[OUTCOME_W-1:0], want);
                pending_reports.push_back(want);
                reqs_accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (pending_reports.size() == 0)
                begin
                    $display("%0t unexpected result expected none got %h", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("link_state", want.link_state, got.link_state);
                    check_field("launch_request", want.launch_request, got.launch_request);
                    check_field("start_taken", want.start_taken, got.start_taken);
                    check_field("retry_delay_ms", want.retry_delay_ms, got.retry_delay_ms);
                    check_field("attempt_number", want.attempt_number, got.attempt_number);
                    check_field("retries_exhausted", want.retries_exhausted,
                                got.retries_exhausted);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_event(input int unsigned op, input int unsigned oc);
        rbc_event_t ev;
        ev.operation = op[OP_W-1:0];
        ev.launch_outcome = oc[OUTCOME_W-1:0];
        event_queue.push_back(ev);
        reqs_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[DELAY_W-1:0];
        case (idx)
            REG_ENABLED:     cfg_q.enabled = value[0];
            REG_CREDENTIALS: cfg_q.credentials_present = value[0];
            REG_AUTO:        cfg_q.auto_reconnect = value[0];
            REG_MAX_RETRIES: cfg_q.max_retries = value[COUNT_W-1:0];
            REG_BASE_DELAY:  cfg_q.base_delay_ms = value[BASE_W-1:0];
            REG_MAX_DELAY:   cfg_q.max_delay_ms = value[DELAY_W-1:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic drain_link();
        wait (reqs_accepted == reqs_queued && pending_reports.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // start, then a random mix of outcomes, live, drops, stops, random operations and tick runs
    task automatic push_session(output int unsigned pushed);
        int unsigned steps;
        int unsigned pick;
        int unsigned oc;
        int unsigned ticks;
        pushed = 1;
        push_event(OP_START, $urandom_range(0, 3));
        steps = $urandom_range(3, 14);
        for (int unsigned i = 0; i < steps; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    pick = $urandom_range(0, 9);
                    oc = (pick < 4) ? OC_OK : (pick < 7) ? OC_START_FAILED :
                         (pick < 9) ? OC_BUILD_FAILED : OC_UNDEFINED;
                    push_event(OP_OUTCOME, oc);
                    pushed++;
                end
                3, 4, 5, 6:
                begin
                    ticks = $urandom_range(1, 20);
                    repeat (ticks) push_event(OP_TICK, $urandom_range(0, 3));
                    pushed += ticks;
                end
                7:
                begin
                    push_event(OP_LIVE, $urandom_range(0, 3));
                    pushed++;
                end
                8:
                begin
                    push_event(OP_DROP, $urandom_range(0, 3));
                    pushed++;
                end
                default:
                begin
                    if ($urandom_range(0, 2) == 0)
                        push_event(OP_STOP, $urandom_range(0, 3));
                    else
                        push_event($urandom_range(0, OP_SPARE_B), $urandom_range(0, 3));
                    pushed++;
                end
            endcase
        end
    endtask

    initial
    begin : stimulus_blk
        int unsigned phase_items;
        int unsigned got_items;
        cfg_q.enabled = 1'b0;
        cfg_q.credentials_present = 1'b0;
        cfg_q.auto_reconnect = 1'b1;
        cfg_q.max_retries = RST_MAX_RETRIES;
        cfg_q.base_delay_ms = RST_BASE_DELAY;
        cfg_q.max_delay_ms = RST_MAX_DELAY;
        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // disabled target, spare operations and undefined outcome
        push_event(OP_START, OC_UNDEFINED);
        push_event(OP_SPARE_A, OC_OK);
        push_event(OP_SPARE_B, OC_UNDEFINED);
        push_event(OP_TICK, OC_OK);
        drain_link();
        write_reg(REG_ENABLED, 1);
        push_event(OP_START, OC_OK);
        drain_link();

        // zero delay retries with the widest limits
        write_reg(REG_CREDENTIALS, 1);
        write_reg(REG_MAX_RETRIES, 255);
        write_reg(REG_BASE_DELAY, 0);
        write_reg(REG_MAX_DELAY, 26'h3FFFFFF);
        push_event(OP_START, OC_OK);
        push_event(OP_OUTCOME, OC_BUILD_FAILED);
        push_event(OP_START, OC_OK);
        push_event(OP_OUTCOME, OC_START_FAILED);
        push_event(OP_OUTCOME, OC_BUILD_FAILED);
        push_event(OP_OUTCOME, OC_OK);
        push_event(OP_OUTCOME, OC_UNDEFINED);
        push_event(OP_LIVE, OC_OK);
        push_event(OP_DROP, OC_OK);
        push_event(OP_STOP, OC_OK);
        push_event(OP_DROP, OC_OK);
        push_event(OP_OUTCOME, OC_OK);
        push_event(OP_LIVE, OC_OK);
        push_event(OP_TICK, OC_OK);
        drain_link();

        // capped delay, then a start cancels the wait
        write_reg(REG_BASE_DELAY, 65535);
        write_reg(REG_MAX_DELAY, 150);
        push_event(OP_START, OC_OK);
        push_event(OP_DROP, OC_OK);
        push_event(OP_TICK, OC_OK);
        push_event(OP_START, OC_OK);
        push_event(OP_TICK, OC_OK);
        drain_link();

        // retry refused without auto reconnect, then limit reached
        write_reg(REG_AUTO, 0);
        write_reg(REG_MAX_RETRIES, 0);
        push_event(OP_DROP, OC_OK);
        drain_link();
        write_reg(REG_AUTO, 1);
        push_event(OP_DROP, OC_OK);
        drain_link();

        for (int unsigned ph = 0; ph < 24; ph++)
        begin
            bursts_on = (ph < 20) && (ph % 3 != 2);
            write_reg(REG_ENABLED, ($urandom_range(0, 9) != 0) ? 1 : 0);
            write_reg(REG_CREDENTIALS, ($urandom_range(0, 9) != 0) ? 1 : 0);
            write_reg(REG_AUTO, ($urandom_range(0, 5) != 0) ? 1 : 0);
            case ($urandom_range(0, 7))
                0:       write_reg(REG_MAX_RETRIES, 0);
                1:       write_reg(REG_MAX_RETRIES, 255);
                default: write_reg(REG_MAX_RETRIES, $urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 7))
                0:       write_reg(REG_BASE_DELAY, 0);
                1:       write_reg(REG_BASE_DELAY, 65535);
                default: write_reg(REG_BASE_DELAY, $urandom_range(1, 400));
            endcase
            case ($urandom_range(0, 7))
                0:       write_reg(REG_MAX_DELAY, 0);
                1:       write_reg(REG_MAX_DELAY, 26'h3FFFFFF);
                default: write_reg(REG_MAX_DELAY, $urandom_range(100, 3000));
            endcase
            phase_items = 0;
            while (phase_items < 25)
            begin
                push_session(got_items);
                phase_items += got_items;
            end
            drain_link();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
